// ----- rtl/core/atrm_pkg.sv -----
package atrm_pkg;

  localparam int unsigned MaxPromptBytes = 8;
  localparam int unsigned MaxTermBytes   = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [7:0] CharCr = 8'h0D;

  typedef enum logic [1:0] {
    PhasePrompt = 2'd0,
    PhaseGather = 2'd1,
    PhaseTerm   = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPromptChars = 3'd0,
    RegPromptLen   = 3'd1,
    RegTermLow     = 3'd2,
    RegTermHigh    = 3'd3,
    RegTermLen     = 3'd4,
    RegRespCap     = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    ActStart = 1'b0,
    ActByte  = 1'b1
  } action_e;

endpackage

// ----- rtl/core/at_response_matcher.sv -----
// An accepted input word passes through the input register and then the result
// register before its result word appears on m_axis. Throughput: one word per
// cycle while m_axis_tready holds; the input register refills while a result waits in the output register.
// Reset (rst_ni, asynchronous, active low): configuration takes its reset
// values, matchers cleared, phase is terminator only, both stages empty.
module at_response_matcher import atrm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // received characters
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  logic                s_axis_tuser,   // [0] action
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [7:0] response_byte, [8] matched,
                                              // [10:9] phase, [15:11] zero
  output logic                m_axis_tuser    // [0] response_valid
);

  // configuration
  logic [63:0] prompt_chars_q;
  logic [3:0]  prompt_len_q;
  logic [127:0] term_chars_q;
  logic [4:0]  term_len_q;
  logic [7:0]  resp_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_chars_q <= '0;
      prompt_len_q   <= '0;
      term_chars_q   <= '0;
      term_len_q     <= 5'd1;
      resp_cap_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegPromptChars: prompt_chars_q       <= cfg_data_i;
        RegPromptLen:   prompt_len_q         <= cfg_data_i[3:0];
        RegTermLow:     term_chars_q[63:0]   <= cfg_data_i;
        RegTermHigh:    term_chars_q[127:64] <= cfg_data_i;
        RegTermLen:     term_len_q           <= cfg_data_i[4:0];
        RegRespCap:     resp_cap_q           <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_q, in_valid_d;
  logic       in_action_q;
  logic [7:0] in_byte_q;
  logic       advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
  end

  // matcher state
  logic [3:0] prompt_pos_q, prompt_pos_d;
  logic [4:0] term_pos_q, term_pos_d;
  phase_e     phase_q, phase_d;
  logic [7:0] room_q, room_d;
  logic       done_q, done_d;
  logic [7:0] resp_byte;
  logic       resp_valid;

  logic [3:0] plen;
  logic [4:0] tlen;
  logic [7:0] prompt_cur, term_cur;

  always_comb begin
    plen = (prompt_len_q > 4'(MaxPromptBytes)) ? 4'(MaxPromptBytes) : prompt_len_q;
    if (term_len_q == 5'd0) begin
      tlen = 5'd1;
    end else if (term_len_q > 5'(MaxTermBytes)) begin
      tlen = 5'(MaxTermBytes);
    end else begin
      tlen = term_len_q;
    end
  end

  assign prompt_cur = prompt_chars_q[{prompt_pos_q[2:0], 3'b000} +: 8];
  assign term_cur   = term_chars_q[{term_pos_q[3:0], 3'b000} +: 8];

  always_comb begin
    prompt_pos_d = prompt_pos_q;
    term_pos_d   = term_pos_q;
    phase_d      = phase_q;
    room_d       = room_q;
    done_d       = done_q;
    resp_byte    = '0;
    resp_valid   = 1'b0;

    if (action_e'(in_action_q) == ActStart) begin
      prompt_pos_d = '0;
      term_pos_d   = '0;
      done_d       = 1'b0;
      room_d       = resp_cap_q;
      phase_d      = (plen != 4'd0) ? PhasePrompt : PhaseTerm;
    end else if (!done_q) begin
      if (plen != 4'd0) begin
        case (phase_q)
          PhasePrompt: begin
            if (in_byte_q == prompt_cur) begin
              prompt_pos_d = prompt_pos_q + 4'd1;
              if (prompt_pos_d >= plen) begin
                phase_d = PhaseGather;
              end
            end else begin
              prompt_pos_d = (in_byte_q == prompt_chars_q[7:0]) ? 4'd1 : 4'd0;
            end
          end
          PhaseGather: begin
            if (resp_cap_q != 8'd0) begin
              if (in_byte_q == CharCr || room_q < 8'd2) begin
                phase_d = PhaseTerm;
              end else begin
                resp_byte  = in_byte_q;
                resp_valid = 1'b1;
                room_d     = room_q - 8'd1;
              end
            end
          end
          default: ;
        endcase
      end

      // terminator matcher runs on every byte, in every phase, until the terminator has matched
      if (in_byte_q == term_cur) begin
        term_pos_d = term_pos_q + 5'd1;
        if (term_pos_d >= tlen) begin
          done_d = 1'b1;
        end
      end else begin
        term_pos_d = (in_byte_q == term_chars_q[7:0]) ? 5'd1 : 5'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prompt_pos_q <= '0;
      term_pos_q   <= '0;
      phase_q      <= PhaseTerm;
      room_q       <= '0;
      done_q       <= 1'b0;
    end else if (advance) begin
      prompt_pos_q <= prompt_pos_d;
      term_pos_q   <= term_pos_d;
      phase_q      <= phase_d;
      room_q       <= room_d;
      done_q       <= done_d;
    end
  end

  // result register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_rv_q;
  logic       out_matched_q;
  phase_e     out_phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q    <= resp_byte;
      out_rv_q      <= resp_valid;
      out_matched_q <= done_d;
      out_phase_q   <= phase_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_phase_q, out_matched_q, out_byte_q};
  assign m_axis_tuser  = out_rv_q;

endmodule

// ----- rtl/core/atrm_checker.sv -----
module atrm_checker import atrm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [15:0]         m_axis_tdata,
  input logic                m_axis_tuser
);

  // a result word that is not taken stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // no gathered character means a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("response byte not zero without response_valid");

  // a gathered character only comes out in the gathering phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:9] == PhaseGather)
    else $error("response byte outside gathering phase");

  // gathering never passes out a carriage return
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] != CharCr)
    else $error("carriage return passed out as response");

  // phase code three never appears and the padding bits [15:11] are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:9] != 2'd3 && m_axis_tdata[15:11] == 5'd0)
    else $error("bad phase or padding in result word");

endmodule

bind at_response_matcher atrm_checker u_atrm_checker (.*);
